// ----- design/fhm_pkg.sv -----
// fhm_pkg: shared types and codes for the FIFO hand-off mutex.
// Request and result word layouts, op and status codes, controller/datapath links.
// No dependencies.
`default_nettype none

package fhm_pkg;

    localparam logic [1:0] OP_LOCK   = 2'd0;
    localparam logic [1:0] OP_TRY    = 2'd1;
    localparam logic [1:0] OP_UNLOCK = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [2:0] ST_GRANTED     = 3'd0;
    localparam logic [2:0] ST_QUEUED      = 3'd1;
    localparam logic [2:0] ST_FREED       = 3'd2;
    localparam logic [2:0] ST_HANDED      = 3'd3;
    localparam logic [2:0] ST_RECURSIVE   = 3'd4;
    localparam logic [2:0] ST_NOT_OWNER   = 3'd5;
    localparam logic [2:0] ST_FULL        = 3'd6;
    localparam logic [2:0] ST_WOULD_BLOCK = 3'd7;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] requester_id;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] subject_id;
        logic [3:0]  waiting_count;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       emit;
        logic       push;
        logic       pop;
        logic       grant;
        logic       free_lock;
        logic [2:0] status;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] op;
        logic       held;
        logic       is_owner;
        logic       full;
        logic       nonempty;
    } dp_flags_t;

endpackage

`default_nettype wire

// ----- design/fhm_ctrl.sv -----
// fhm_ctrl: sequencer and decision logic for the FIFO hand-off mutex.
// Depends on fhm_pkg; drives fhm_dpath through dp_cmd_t.
`default_nettype none

module fhm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire fhm_pkg::dp_flags_t flags,
    output fhm_pkg::dp_cmd_t       cmd,
    output logic                   busy,
    output logic                   result_valid
);
    import fhm_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_WOULD_BLOCK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
                unique case (flags.op)
                    OP_LOCK, OP_TRY:
                    begin
                        priority if (!flags.held)
                        begin
                            cmd.grant  = 1'b1;
                            cmd.status = ST_GRANTED;
                        end
                        else if (flags.op == OP_TRY)
                            cmd.status = ST_WOULD_BLOCK;
                        else if (flags.is_owner)
                            cmd.status = ST_RECURSIVE;
                        else if (flags.full)
                            cmd.status = ST_FULL;
                        else
                        begin
                            cmd.push   = 1'b1;
                            cmd.status = ST_QUEUED;
                        end
                    end
                    OP_UNLOCK:
                    begin
                        priority if (!flags.held || !flags.is_owner)
                            cmd.status = ST_NOT_OWNER;
                        else if (flags.nonempty)
                        begin
                            cmd.pop    = 1'b1;
                            cmd.status = ST_HANDED;
                        end
                        else
                        begin
                            cmd.free_lock = 1'b1;
                            cmd.status    = ST_FREED;
                        end
                    end
                    OP_NONE:
                        cmd.status = ST_WOULD_BLOCK;
                    default:
                        cmd.status = ST_WOULD_BLOCK;
                endcase
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= cmd.emit;
        end
    end

    assign busy         = (state_reg == S_EXEC);
    assign result_valid = valid_reg;

endmodule

`default_nettype wire

// ----- design/fhm_dpath.sv -----
// fhm_dpath: lock state, waiter queue memory, pointers and result register.
// Depends on fhm_pkg; commanded by fhm_ctrl.
`default_nettype none

module fhm_dpath #(
    parameter int QUEUE_DEPTH = 8,
    parameter int ID_WIDTH    = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fhm_pkg::req_t     request,
    input  wire fhm_pkg::dp_cmd_t  cmd,
    output fhm_pkg::dp_flags_t     flags,
    output fhm_pkg::rsp_t          result
);
    import fhm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [ID_WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0] head_data_reg;

    logic [1:0]          op_reg;
    logic [ID_WIDTH-1:0] id_reg;
    logic                held_reg,  held_next;
    logic [ID_WIDTH-1:0] owner_reg, owner_next;
    logic [PTR_W-1:0]    head_reg,  head_next;
    logic [PTR_W-1:0]    tail_reg,  tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W+3:0]    count_ext;
    rsp_t                rsp_reg;

    always_comb
    begin
        held_next  = held_reg;
        owner_next = owner_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.grant)
        begin
            held_next  = 1'b1;
            owner_next = id_reg;
        end
        if (cmd.free_lock)
        begin
            held_next  = 1'b0;
            owner_next = '0;
        end
        if (cmd.pop)
        begin
            owner_next = head_data_reg;
            head_next  = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (cmd.push)
        begin
            tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
    end

    assign count_ext = {4'b0, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 1'b0;
            owner_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            held_reg  <= held_next;
            owner_reg <= owner_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // queue memory: write at tail, read at head every cycle
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            mem[tail_reg] <= id_reg;
        head_data_reg <= mem[head_reg];
    end

    // request and result words
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= request.op;
            id_reg <= ID_WIDTH'(request.requester_id);
        end
        if (cmd.emit)
        begin
            rsp_reg.status        <= cmd.status;
            rsp_reg.subject_id    <= cmd.pop ? 16'(head_data_reg) : 16'(id_reg);
            rsp_reg.waiting_count <= count_ext[3:0];
        end
    end

    assign flags.op       = op_reg;
    assign flags.held     = held_reg;
    assign flags.is_owner = (id_reg == owner_reg);
    assign flags.full     = (count_reg == CNT_FULL);
    assign flags.nonempty = (count_reg != '0);
    assign result         = rsp_reg;

endmodule

`default_nettype wire

// ----- design/fifo_handoff_mutex.sv -----
// fifo_handoff_mutex: hardware mutex with a FIFO of waiters and owner hand-off.
// Top level; instantiates fhm_ctrl and fhm_dpath, uses fhm_pkg.
//
//   channel   | handshake                 | word
//   ----------+---------------------------+---------------------------------
//   request   | start && !busy            | op, requester_id
//   result    | result_valid (one cycle)  | status, subject_id, waiting_count
//
// Each request is accepted, then run in the execute state with busy high;
// the result strobe follows in the next cycle, during which a new request
// may already be accepted. The execute state is there for the waiter
// memory, whose head word is read into a register at the accept edge.
// Reset frees the lock and empties the queue at once; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module fifo_handoff_mutex #(
    parameter int QUEUE_DEPTH = 8,
    parameter int ID_WIDTH    = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire fhm_pkg::req_t  request,
    output logic                result_valid,
    output fhm_pkg::rsp_t       result
);
    import fhm_pkg::*;

    dp_cmd_t   cmd;
    dp_flags_t flags;

    fhm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .flags        (flags),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    fhm_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .flags   (flags),
        .result  (result)
    );

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not enter execute");

    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (!busy && result_valid))
        else $error("execute did not finish in one cycle with a result");

    a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without an execute cycle");

    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.push, cmd.pop, cmd.grant, cmd.free_lock}))
        else $error("conflicting lock updates in one cycle");

endmodule

`default_nettype wire
